// ----- rtl/hpm_pkg.sv -----
// Package for the Huffman pair merger: sizes, op codes, sequencer states.
package hpm_pkg;

   // table geometry
   localparam int BINS        = 256;
   localparam int BIN_W       = (BINS > 2) ? $clog2(BINS) : 1;
   localparam int COUNT_WIDTH = 32;
   localparam int LIVE_W      = BIN_W + 1;

   // largest count a bin can hold
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // request op codes
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_MERGE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // merge sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE
   } state_type;

endpackage

// ----- rtl/hpm_req_if.sv -----
// Request channel interface: valid/ready handshake with op, bin and count.
interface hpm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  bin;
   logic [31:0] count;

   modport source (output valid, output op, output bin, output count, input ready);
   modport sink   (input valid, input op, input bin, input count, output ready);
endinterface

// ----- rtl/hpm_rsp_if.sv -----
// Response channel interface: valid/ready handshake with the merged pair.
interface hpm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pair_low;
   logic [7:0] pair_high;
   logic       exhausted;

   modport source (output valid, output pair_low, output pair_high, output exhausted,
                   input ready);
   modport sink   (input valid, input pair_low, input pair_high, input exhausted,
                   output ready);
endinterface

// ----- rtl/huffman_pair_merger.sv -----
// Huffman pair merger: count table with a sequential two-minimum scan.
// Load, clear and unknown words finish in the idle state. A merge, with requests
// held off, reads the table one bin at a time, drains the last compare and writes
// back when the response slot is free; with under two live bins it skips the scan.
// The scan is paced by the single read port of the count memory: one bin a cycle.
// Synchronous reset clears the live flags and live counter at once; no clearing pass.
module huffman_pair_merger
   import hpm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hpm_req_if.sink    req,
   hpm_rsp_if.source  rsp
);

   // count memory, read data registered
   logic [COUNT_WIDTH-1:0] mem [BINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   // per-bin live flags: nonzero count and not removed
   logic [BINS-1:0]   live_ff, live_in;
   logic [LIVE_W-1:0] live_count_ff, live_count_in;

   state_type state_ff, state_in;

   // scan address and read pipeline
   logic [BIN_W-1:0] addr_ff, addr_in;
   logic             pipe_v_ff, pipe_v_in;
   logic [BIN_W-1:0] pipe_idx_ff;
   logic             pipe_live_ff;

   // running minima
   logic                   have1_ff, have1_in, have2_ff, have2_in;
   logic [COUNT_WIDTH-1:0] min1_ff, min1_in, min2_ff, min2_in;
   logic [BIN_W-1:0]       pos1_ff, pos1_in, pos2_ff, pos2_in;
   logic                   exh_ff, exh_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_low_ff, rsp_low_in, rsp_high_ff, rsp_high_in;
   logic             rsp_exh_ff, rsp_exh_in;

   // memory write port
   logic                   we;
   logic [BIN_W-1:0]       waddr;
   logic [COUNT_WIDTH-1:0] wdata;

   // request decode
   logic                   req_fire;
   logic                   bin_ok;
   logic [BIN_W-1:0]       ld_idx;
   logic [COUNT_WIDTH-1:0] ld_count;
   logic                   ld_nz;
   logic [COUNT_WIDTH:0]   sum_wide;
   logic [COUNT_WIDTH-1:0] sum_sat;
   logic                   rsp_free;
   logic [BIN_W-1:0]       lo_idx, hi_idx;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign bin_ok    = (32'(req.bin) < 32'(BINS));
   assign ld_idx    = BIN_W'(req.bin);
   assign ld_count  = (64'(req.count) > 64'(COUNT_MAX)) ? COUNT_MAX
                                                         : COUNT_WIDTH'(req.count);
   assign ld_nz     = (ld_count != '0);

   // saturating merge sum
   assign sum_wide = {1'b0, min1_ff} + {1'b0, min2_ff};
   assign sum_sat  = sum_wide[COUNT_WIDTH] ? COUNT_MAX : sum_wide[COUNT_WIDTH-1:0];

   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign lo_idx   = (pos1_ff < pos2_ff) ? pos1_ff : pos2_ff;
   assign hi_idx   = (pos1_ff < pos2_ff) ? pos2_ff : pos1_ff;

   // sequencer: next state, scan compare and table updates
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      pipe_v_in     = 1'b0;
      have1_in      = have1_ff;
      have2_in      = have2_ff;
      min1_in       = min1_ff;
      min2_in       = min2_ff;
      pos1_in       = pos1_ff;
      pos2_in       = pos2_ff;
      exh_in        = exh_ff;
      live_in       = live_ff;
      live_count_in = live_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_low_in    = rsp_low_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_exh_in    = rsp_exh_ff;
      we            = 1'b0;
      waddr         = ld_idx;
      wdata         = ld_count;

      // compare the word read in the previous cycle
      if (pipe_v_ff && pipe_live_ff) begin
         if (!have1_ff || rd_data_ff < min1_ff) begin
            min2_in  = min1_ff;
            pos2_in  = pos1_ff;
            have2_in = have1_ff;
            min1_in  = rd_data_ff;
            pos1_in  = pipe_idx_ff;
            have1_in = 1'b1;
         end else if (!have2_ff || rd_data_ff < min2_ff) begin
            min2_in  = rd_data_ff;
            pos2_in  = pipe_idx_ff;
            have2_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (op_type'(req.op))
                  OP_LOAD: begin
                     if (bin_ok) begin
                        we              = 1'b1;
                        live_in[ld_idx] = ld_nz;
                        if (live_ff[ld_idx] && !ld_nz) begin
                           live_count_in = live_count_ff - LIVE_W'(1);
                        end else if (!live_ff[ld_idx] && ld_nz) begin
                           live_count_in = live_count_ff + LIVE_W'(1);
                        end
                     end
                  end
                  OP_MERGE: begin
                     have1_in = 1'b0;
                     have2_in = 1'b0;
                     addr_in  = '0;
                     if (live_count_ff < LIVE_W'(2)) begin
                        exh_in   = 1'b1;
                        state_in = ST_WRITE;
                     end else begin
                        exh_in   = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     live_in       = '0;
                     live_count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            pipe_v_in = 1'b1;
            addr_in   = addr_ff + BIN_W'(1);
            if (addr_ff == BIN_W'(BINS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (exh_ff || !have2_ff) begin
                  rsp_low_in  = '0;
                  rsp_high_in = '0;
                  rsp_exh_in  = 1'b1;
               end else begin
                  rsp_low_in       = 8'(lo_idx);
                  rsp_high_in      = 8'(hi_idx);
                  rsp_exh_in       = 1'b0;
                  we               = 1'b1;
                  waddr            = pos1_ff;
                  wdata            = sum_sat;
                  live_in[pos2_ff] = 1'b0;
                  if (live_count_ff != '0) begin
                     live_count_in = live_count_ff - LIVE_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         live_ff       <= '0;
         live_count_ff <= '0;
         pipe_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         live_count_ff <= live_count_in;
         pipe_v_ff     <= pipe_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      pipe_idx_ff  <= addr_ff;
      pipe_live_ff <= live_ff[addr_ff];
      have1_ff     <= have1_in;
      have2_ff     <= have2_in;
      min1_ff      <= min1_in;
      min2_ff      <= min2_in;
      pos1_ff      <= pos1_in;
      pos2_ff      <= pos2_in;
      exh_ff       <= exh_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_exh_ff   <= rsp_exh_in;
   end

   // count memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.pair_low  = rsp_low_ff;
   assign rsp.pair_high = rsp_high_ff;
   assign rsp.exhausted = rsp_exh_ff;

   // live counter never exceeds the number of bins
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= LIVE_W'(BINS))
      else $error("live count above bin count");

   // a completed merge names two different bins
   a_pair_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && rsp_free && !exh_ff && have2_ff) |-> (pos1_ff != pos2_ff))
      else $error("merge picked the same bin twice");

   // a clear leaves the table empty
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.op == OP_CLEAR) |=> (live_count_ff == '0 && live_ff == '0))
      else $error("clear left live bins");

   // a new response is loaded only from the write-back state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_WRITE)
      else $error("response raised outside write back");

endmodule

// ----- sim/hpm_merge_checker.sv -----
// Scoreboard for the Huffman pair merger: count table predictor and result compare.
module hpm_merge_checker
   import hpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_bin,
   input  logic [31:0] req_count,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_pair_low,
   input  logic [7:0]  rsp_pair_high,
   input  logic        rsp_exhausted,
   output int          mismatch_count,
   output int          outstanding
);

   typedef struct packed {
      logic [7:0] pair_low;
      logic [7:0] pair_high;
      logic       exhausted;
   } merge_pair_type;

   // shadow copy of the frequency table
   logic [COUNT_WIDTH-1:0] bin_count [BINS];
   logic                   bin_removed [BINS];
   logic [LIVE_W-1:0]      live_bins;

   merge_pair_type expected_pairs [$];
   int             errors = 0;

   function automatic logic is_live(input int b);
      return (bin_count[b] != '0) && !bin_removed[b];
   endfunction

   task automatic clear_table();
      for (int i = 0; i < BINS; i++) begin
         bin_count[i]   = '0;
         bin_removed[i] = 1'b0;
      end
      live_bins = '0;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // apply one accepted request word to the shadow table
   task automatic apply_word(input op_type op, input logic [7:0] b, input logic [31:0] c);
      logic                   was_live;
      logic [COUNT_WIDTH-1:0] new_count;
      logic                   have1;
      logic                   have2;
      logic [COUNT_WIDTH-1:0] min1;
      logic [COUNT_WIDTH-1:0] min2;
      int                     pos1;
      int                     pos2;
      logic [COUNT_WIDTH:0]   sum;
      merge_pair_type         pair;
      case (op)
         OP_LOAD: begin
            // out-of-range bins are dropped; reload clears the removed mark
            if (int'(b) < BINS) begin
               was_live  = is_live(int'(b));
               new_count = (c > COUNT_MAX) ? COUNT_MAX : c[COUNT_WIDTH-1:0];
               bin_count[b]   = new_count;
               bin_removed[b] = 1'b0;
               if (was_live && new_count == '0)
                  live_bins = live_bins - LIVE_W'(1);
               else if (!was_live && new_count != '0)
                  live_bins = live_bins + LIVE_W'(1);
            end
         end
         OP_MERGE: begin
            have1 = 1'b0;
            have2 = 1'b0;
            min1  = '0;
            min2  = '0;
            pos1  = 0;
            pos2  = 0;
            // two-minimum scan, ties to the lower index
            for (int p = 0; p < BINS; p++) begin
               if (!is_live(p))
                  continue;
               if (!have1 || bin_count[p] < min1) begin
                  if (have1) begin
                     min2  = min1;
                     pos2  = pos1;
                     have2 = 1'b1;
                  end
                  min1  = bin_count[p];
                  pos1  = p;
                  have1 = 1'b1;
               end else if (!have2 || bin_count[p] < min2) begin
                  min2  = bin_count[p];
                  pos2  = p;
                  have2 = 1'b1;
               end
            end
            if (!have2) begin
               pair.pair_low  = '0;
               pair.pair_high = '0;
               pair.exhausted = 1'b1;
            end else begin
               // saturating add into the smaller bin, retire the other
               sum = {1'b0, min1} + {1'b0, min2};
               bin_count[pos1]   = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
               bin_removed[pos2] = 1'b1;
               if (live_bins != '0)
                  live_bins = live_bins - LIVE_W'(1);
               pair.pair_low  = 8'((pos1 < pos2) ? pos1 : pos2);
               pair.pair_high = 8'((pos1 < pos2) ? pos2 : pos1);
               pair.exhausted = 1'b0;
            end
            expected_pairs.push_back(pair);
         end
         OP_CLEAR: clear_table();
         default: ;
      endcase
   endtask

   // compare one accepted result word with the oldest prediction
   task automatic check_pair();
      merge_pair_type want;
      if (expected_pairs.size() == 0) begin
         report_mismatch("result word with no merge pending, pair_low", rsp_pair_low, -1);
         return;
      end
      want = expected_pairs.pop_front();
      if (rsp_pair_low !== want.pair_low)
         report_mismatch("pair_low", rsp_pair_low, want.pair_low);
      if (rsp_pair_high !== want.pair_high)
         report_mismatch("pair_high", rsp_pair_high, want.pair_high);
      if (rsp_exhausted !== want.exhausted)
         report_mismatch("exhausted", rsp_exhausted, want.exhausted);
   endtask

   // results are checked before the same edge's request is predicted
   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         expected_pairs.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_pair();
         if (req_valid && req_ready)
            apply_word(op_type'(req_op), req_bin, req_count);
      end
      mismatch_count <= errors;
      outstanding    <= expected_pairs.size();
   end

endmodule

// ----- sim/tb_huffman_pair_merger.sv -----
// Testbench top for the Huffman pair merger: stimulus, stall patterns and verdict.
module tb_huffman_pair_merger
   import hpm_pkg::*;
();

   logic clock;
   logic reset;
   int   mismatch_count;
   int   outstanding;
   int   words_sent;
   int   burst_left;

   hpm_req_if req_ch ();
   hpm_rsp_if rsp_ch ();

   huffman_pair_merger i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   hpm_merge_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_op         (req_ch.op),
      .req_bin        (req_ch.bin),
      .req_count      (req_ch.count),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_pair_low   (rsp_ch.pair_low),
      .rsp_pair_high  (rsp_ch.pair_high),
      .rsp_exhausted  (rsp_ch.exhausted),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #12_000_000;
      $display("tb: failure");
      $finish;
   end

   // count mix: absent, tiny (ties), mid, full range, near saturation
   function automatic logic [31:0] rand_count();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1, 2, 3: return 32'($urandom_range(1, 6));
         4, 5:    return 32'($urandom_range(1, 1000));
         6, 7:    return $urandom;
         default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      endcase
   endfunction

   // bins: a narrow cluster for collisions or anywhere in the table
   function automatic logic [7:0] rand_bin(input logic narrow);
      if (narrow)
         return 8'($urandom_range(0, 15)) | (8'($urandom_range(0, 1)) << 7);
      return 8'($urandom_range(0, 255));
   endfunction

   // offer one request word in bursts with random gaps
   task automatic send_word(input op_type op, input logic [7:0] b, input logic [31:0] c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 7))
            0, 1, 2: gap = 0;
            3:       gap = $urandom_range(20, 300);
            default: gap = $urandom_range(1, 12);
         endcase
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.bin   <= b;
      req_ch.count <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (op != OP_NONE)
         words_sent++;
   endtask

   // result side: own stall pattern plus one long hold-off
   initial begin
      int   mode;
      int   mode_left;
      int   hold_left;
      int   cyc;
      logic hold_done;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      cyc       = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (!hold_done && words_sent >= 400) begin
            hold_left = 2500;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 600);
            end
            mode_left--;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= ($urandom_range(0, 7) == 0);
               default: rsp_ch.ready <= ((cyc % 5) != 0);
            endcase
         end
      end
   end

   // request side: reset, directed words, random episodes, drain, verdict
   initial begin
      int   n;
      logic narrow;
      words_sent = 0;
      burst_left = 0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_LOAD;
      req_ch.bin   <= '0;
      req_ch.count <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty table, then a single live bin: both exhausted
      send_word(OP_MERGE, 8'hFF, 32'hFFFF_FFFF);
      send_word(OP_LOAD, 8'h00, 32'd1);
      send_word(OP_MERGE, 8'h00, 32'd0);
      // extreme bin and count, sum saturates into bin 0
      send_word(OP_LOAD, 8'hFF, 32'hFFFF_FFFF);
      send_word(OP_MERGE, 8'h00, 32'd0);
      send_word(OP_MERGE, 8'h00, 32'd0);
      // reload of a removed bin, then a tie between equal counts
      send_word(OP_LOAD, 8'hFF, 32'd5);
      send_word(OP_LOAD, 8'h07, 32'd5);
      send_word(OP_MERGE, 8'h00, 32'd0);
      // zero count makes a bin absent; unknown op does nothing
      send_word(OP_LOAD, 8'h07, 32'd0);
      send_word(OP_NONE, 8'hAA, 32'h5555_5555);
      send_word(OP_MERGE, 8'h55, 32'hAAAA_AAAA);
      send_word(OP_CLEAR, 8'h55, 32'hAAAA_AAAA);
      // two maximum counts saturate
      send_word(OP_LOAD, 8'h80, 32'hFFFF_FFFF);
      send_word(OP_LOAD, 8'h01, 32'hFFFF_FFFF);
      send_word(OP_MERGE, 8'h00, 32'd0);
      // three-way tie and a follow-up merge
      send_word(OP_LOAD, 8'h02, 32'd1);
      send_word(OP_LOAD, 8'h03, 32'd1);
      send_word(OP_LOAD, 8'h04, 32'd1);
      send_word(OP_MERGE, 8'h00, 32'd0);
      send_word(OP_MERGE, 8'h00, 32'd0);
      send_word(OP_CLEAR, 8'h00, 32'd0);
      send_word(OP_MERGE, 8'h00, 32'd0);

      // random part: mostly load-then-merge episodes, some noise
      while (words_sent < 1350) begin
         if ($urandom_range(0, 6) != 0) begin
            if ($urandom_range(0, 2) != 0)
               send_word(OP_CLEAR, 8'($urandom), $urandom);
            n      = $urandom_range(2, 10);
            narrow = 1'($urandom_range(0, 1));
            for (int k = 0; k < n; k++)
               send_word(OP_LOAD, rand_bin(narrow), rand_count());
            // merge past exhaustion, sometimes reloading on the way
            for (int k = 0; k <= n; k++) begin
               if ($urandom_range(0, 7) == 0)
                  send_word(OP_LOAD, rand_bin(narrow), rand_count());
               send_word(OP_MERGE, 8'($urandom), $urandom);
            end
         end else begin
            send_word(op_type'($urandom_range(0, 3)), 8'($urandom), rand_count());
         end
      end
      req_ch.valid <= 1'b0;

      // let the checker count the last accepted word, drain, then catch late words
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/hpm_pkg.sv
rtl/hpm_req_if.sv
rtl/hpm_rsp_if.sv
rtl/huffman_pair_merger.sv
sim/hpm_merge_checker.sv
sim/tb_huffman_pair_merger.sv
